>>> hdl/mwo_pkg.sv
// Shared constants, types and codes for the morphing wavetable oscillator.
`timescale 1ns / 1ps

package mwo_pkg;

    // Store geometry
    localparam int MAX_SETS       = 4;
    localparam int TABLES_PER_SET = 8;
    localparam int TABLE_LEN      = 2048;

    localparam int SET_W   = $clog2(MAX_SETS);
    localparam int TAB_W   = $clog2(TABLES_PER_SET);
    localparam int SMP_W   = $clog2(TABLE_LEN);
    localparam int LIM_AW  = SET_W + TAB_W;
    localparam int STORE_AW = SET_W + TAB_W + SMP_W;
    localparam int LIM_DEPTH   = MAX_SETS * TABLES_PER_SET;
    localparam int STORE_DEPTH = MAX_SETS * TABLES_PER_SET * TABLE_LEN;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 32;
    localparam int MORPH_W  = 17;
    localparam int FRAC_W   = 16;
    localparam int NSET_W   = 3;
    localparam int CNT_W    = 4;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Shared multiplier geometry: signed difference times unsigned fraction
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + PHASE_W + 1;

    // Stream word layout
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    // Input word kinds
    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_LIMIT   = 2'd1,
        CMD_COUNT   = 2'd2,
        CMD_PRODUCE = 2'd3
    } cmd_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MORPH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SETS   = 2'd2;

    // Read requests from the sequencer to the stores
    typedef struct packed {
        logic [LIM_AW-1:0]   lim_raddr;
        logic [STORE_AW-1:0] smp_raddr;
    } rd_req_t;

    // Finished result offered by the sequencer
    typedef struct packed {
        logic                valid;
        logic                found;
        logic [SAMPLE_W-1:0] sample;
    } res_t;

endpackage

>>> hdl/mwo_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mwo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/mwo_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
`timescale 1ns / 1ps

module mwo_mul (
    input  logic                                clk,
    input  logic signed [mwo_pkg::DIFF_W-1:0]   op_a,
    input  logic        [mwo_pkg::PHASE_W-1:0]  op_b,
    output logic signed [mwo_pkg::PROD_W-1:0]   prod
);

    logic signed [mwo_pkg::PROD_W-1:0] prod_reg;
    logic signed [mwo_pkg::PROD_W-1:0] prod_next;

    // Widen both operands and multiply
    assign prod_next = mwo_pkg::PROD_W'(op_a) * $signed(mwo_pkg::PROD_W'({1'b0, op_b}));

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

>>> hdl/mwo_ctrl.sv
// Sequencer and datapath for one output sample: table scan, interpolation, crossfade.
`timescale 1ns / 1ps

module mwo_ctrl (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic [mwo_pkg::PHASE_W-1:0]              phase_step,
    input  logic [mwo_pkg::MORPH_W-1:0]              morph_amount,
    input  logic [mwo_pkg::NSET_W-1:0]               num_sets,
    input  logic [mwo_pkg::MAX_SETS-1:0][mwo_pkg::CNT_W-1:0] set_counts,
    input  logic [mwo_pkg::PHASE_W-1:0]              lim_rdata,
    input  logic [mwo_pkg::SAMPLE_W-1:0]             smp_rdata,
    input  logic signed [mwo_pkg::PROD_W-1:0]        prod,
    input  logic                                     out_free,
    output mwo_pkg::rd_req_t                         rd,
    output logic signed [mwo_pkg::DIFF_W-1:0]        mul_a,
    output logic [mwo_pkg::PHASE_W-1:0]              mul_b,
    output logic                                     idle,
    output mwo_pkg::res_t                            res
);

    localparam int MPOS_W = mwo_pkg::MORPH_W + mwo_pkg::NSET_W;
    localparam int PPOS_W = mwo_pkg::PHASE_W + mwo_pkg::SMP_W;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_SETUP = 12'b0000_0000_0010,
        ST_LADDR = 12'b0000_0000_0100,
        ST_LCMP  = 12'b0000_0000_1000,
        ST_RDA   = 12'b0000_0001_0000,
        ST_RDB   = 12'b0000_0010_0000,
        ST_WAITB = 12'b0000_0100_0000,
        ST_ACC   = 12'b0000_1000_0000,
        ST_XMUL  = 12'b0001_0000_0000,
        ST_XACC  = 12'b0010_0000_0000,
        ST_DONE  = 12'b0100_0000_0000,
        ST_SPARE = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [mwo_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [mwo_pkg::NSET_W-1:0]   n_reg, n_next;
    logic [mwo_pkg::NSET_W-1:0]   idx_reg, idx_next;
    logic [mwo_pkg::FRAC_W-1:0]   frac_reg, frac_next;
    logic [mwo_pkg::SMP_W-1:0]    i_reg, i_next;
    logic [mwo_pkg::PHASE_W-1:0]  f_reg, f_next;
    logic [mwo_pkg::SET_W-1:0]    set_reg, set_next;
    logic [mwo_pkg::TAB_W-1:0]    t_reg, t_next;
    logic [mwo_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                         second_reg, second_next;
    logic                         found_reg, found_next;
    logic [mwo_pkg::SAMPLE_W-1:0] a_reg, a_next;
    logic [mwo_pkg::SAMPLE_W-1:0] v1_reg, v1_next;
    logic [mwo_pkg::SAMPLE_W-1:0] v2_reg, v2_next;
    logic [mwo_pkg::SAMPLE_W-1:0] out_reg, out_next;

    logic [mwo_pkg::NSET_W-1:0]   n_c;
    logic [MPOS_W-1:0]            mpos_c;
    logic [PPOS_W-1:0]            ppos_c;
    logic [mwo_pkg::NSET_W-1:0]   idx_c;
    logic [mwo_pkg::NSET_W-1:0]   nxt_c;
    logic [mwo_pkg::SMP_W-1:0]    j_c;
    logic [mwo_pkg::SAMPLE_W-1:0] b_off_c;
    logic signed [mwo_pkg::PROD_W-1:0] sumi_c;
    logic signed [mwo_pkg::PROD_W-1:0] sumx_c;
    logic signed [mwo_pkg::SAMPLE_W+1:0] interp_c;
    logic signed [mwo_pkg::SAMPLE_W+1:0] xfade_c;

    // Morph position and table read position
    assign n_c    = (num_sets > mwo_pkg::NSET_W'(mwo_pkg::MAX_SETS)) ?
                    mwo_pkg::NSET_W'(mwo_pkg::MAX_SETS) : num_sets;
    assign mpos_c = MPOS_W'(morph_amount) * MPOS_W'(n_c - 1'b1);
    assign idx_c  = mpos_c[mwo_pkg::FRAC_W +: mwo_pkg::NSET_W];
    assign ppos_c = PPOS_W'(phase_reg) * PPOS_W'(mwo_pkg::TABLE_LEN - 1);
    assign nxt_c  = idx_reg + 1'b1;
    assign j_c    = (i_reg == mwo_pkg::SMP_W'(mwo_pkg::TABLE_LEN - 1)) ? '0 : i_reg + 1'b1;

    // Offset samples to unsigned, round the shared products
    assign b_off_c  = smp_rdata ^ {1'b1, {(mwo_pkg::SAMPLE_W-1){1'b0}}};
    assign sumi_c   = prod + $signed(mwo_pkg::PROD_W'(64'h8000_0000));
    assign sumx_c   = prod + $signed(mwo_pkg::PROD_W'(32'h8000));
    assign interp_c = $signed({2'b00, a_reg}) +
                      $signed(sumi_c[mwo_pkg::PROD_W-1 -: (mwo_pkg::SAMPLE_W+2)]);
    assign xfade_c  = $signed({2'b00, v1_reg}) +
                      $signed(sumx_c[mwo_pkg::FRAC_W +: (mwo_pkg::SAMPLE_W+2)]);

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        frac_next   = frac_reg;
        i_next      = i_reg;
        f_next      = f_reg;
        set_next    = set_reg;
        t_next      = t_reg;
        cnt_next    = cnt_reg;
        second_next = second_reg;
        found_next  = found_reg;
        a_next      = a_reg;
        v1_next     = v1_reg;
        v2_next     = v2_reg;
        out_next    = out_reg;
        mul_a       = '0;
        mul_b       = '0;
        rd.lim_raddr = {set_reg, t_reg};
        rd.smp_raddr = {set_reg, t_reg, i_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SETUP;
                end
            end
            // Pick the set pair and latch the read position
            ST_SETUP:
            begin
                n_next      = n_c;
                idx_next    = idx_c;
                frac_next   = mpos_c[mwo_pkg::FRAC_W-1:0];
                i_next      = ppos_c[PPOS_W-1 -: mwo_pkg::SMP_W];
                f_next      = ppos_c[mwo_pkg::PHASE_W-1:0];
                second_next = 1'b0;
                t_next      = '0;
                set_next    = idx_c[mwo_pkg::SET_W-1:0];
                cnt_next    = set_counts[idx_c[mwo_pkg::SET_W-1:0]];
                if (n_c == '0 || idx_c >= n_c ||
                    set_counts[idx_c[mwo_pkg::SET_W-1:0]] == '0)
                begin
                    // Silence: offset midpoint reads back as zero
                    found_next = 1'b0;
                    out_next   = {1'b1, {(mwo_pkg::SAMPLE_W-1){1'b0}}};
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_LADDR;
                end
            end
            ST_LADDR:
            begin
                state_next = ST_LCMP;
            end
            // Advance to the next table while this one is too low
            ST_LCMP:
            begin
                if ((mwo_pkg::CNT_W'(t_reg) + 1'b1) < cnt_reg && phase_step > lim_rdata)
                begin
                    t_next     = t_reg + 1'b1;
                    state_next = ST_LADDR;
                end
                else
                begin
                    state_next = ST_RDA;
                end
            end
            ST_RDA:
            begin
                state_next = ST_RDB;
            end
            ST_RDB:
            begin
                rd.smp_raddr = {set_reg, t_reg, j_c};
                a_next       = b_off_c;
                state_next   = ST_WAITB;
            end
            // Difference of neighbours times the position fraction
            ST_WAITB:
            begin
                mul_a      = $signed({1'b0, b_off_c}) - $signed({1'b0, a_reg});
                mul_b      = f_reg;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (!second_reg)
                begin
                    v1_next = interp_c[mwo_pkg::SAMPLE_W-1:0];
                    if (nxt_c < n_reg && set_counts[nxt_c[mwo_pkg::SET_W-1:0]] != '0)
                    begin
                        second_next = 1'b1;
                        set_next    = nxt_c[mwo_pkg::SET_W-1:0];
                        cnt_next    = set_counts[nxt_c[mwo_pkg::SET_W-1:0]];
                        t_next      = '0;
                        state_next  = ST_LADDR;
                    end
                    else
                    begin
                        out_next   = interp_c[mwo_pkg::SAMPLE_W-1:0];
                        found_next = 1'b1;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    v2_next    = interp_c[mwo_pkg::SAMPLE_W-1:0];
                    state_next = ST_XMUL;
                end
            end
            // Crossfade between the two sets
            ST_XMUL:
            begin
                mul_a      = $signed({1'b0, v2_reg}) - $signed({1'b0, v1_reg});
                mul_b      = mwo_pkg::PHASE_W'(frac_reg);
                state_next = ST_XACC;
            end
            ST_XACC:
            begin
                out_next   = xfade_c[mwo_pkg::SAMPLE_W-1:0];
                found_next = 1'b1;
                state_next = ST_DONE;
            end
            // Hand over the result, advance the phase on a real sample
            ST_DONE:
            begin
                if (out_free)
                begin
                    if (found_reg)
                    begin
                        phase_next = phase_reg + phase_step;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Working values
    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        idx_reg    <= idx_next;
        frac_reg   <= frac_next;
        i_reg      <= i_next;
        f_reg      <= f_next;
        set_reg    <= set_next;
        t_reg      <= t_next;
        cnt_reg    <= cnt_next;
        second_reg <= second_next;
        found_reg  <= found_next;
        a_reg      <= a_next;
        v1_reg     <= v1_next;
        v2_reg     <= v2_next;
        out_reg    <= out_next;
    end

    assign idle       = (state_reg == ST_IDLE);
    assign res.valid  = (state_reg == ST_DONE);
    assign res.found  = found_reg;
    assign res.sample = out_reg ^ {1'b1, {(mwo_pkg::SAMPLE_W-1){1'b0}}};

endmodule

>>> hdl/morphing_wavetable_oscillator_top.sv
// Top level of the morphing wavetable oscillator: ports, stores, config, output register.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tuser = cmd; s_tdata = load fields
// m_*      out  m_tvalid/m_tready  m_tdata = sample_out; m_tuser = table_found
// cfg_*    in   cfg_we             cfg_index selects register, cfg_data value
//
// Load words are taken while the sequencer is idle and leave the input open. A
// produce word scans the table limits of each set through the limit RAM and
// uses the shared multiplier once per set and once for the crossfade; a silent
// word skips both and yields zero.
// Reset clears the phase, configuration and set table counts; sample and limit
// stores are undefined until written. A stalled output holds the finished word
// and the sequencer waits in its last step; the input stays closed meanwhile.
`timescale 1ns / 1ps

module morphing_wavetable_oscillator_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // set_index[1:0], table_index[4:2], sample_index[15:5], sample_value[31:16],
    // top_limit[63:32], table_count[67:64], zero[71:68]
    input  logic [mwo_pkg::S_TDATA_W-1:0]        s_tdata,
    // cmd[1:0]
    input  logic [mwo_pkg::S_TUSER_W-1:0]        s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // sample_out[15:0]
    output logic [mwo_pkg::M_TDATA_W-1:0]        m_tdata,
    // table_found[0]
    output logic                                 m_tuser,
    input  logic                                 cfg_we,
    input  logic [mwo_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mwo_pkg::CFG_W-1:0]            cfg_data
);

    logic [mwo_pkg::PHASE_W-1:0] phase_step_reg;
    logic [mwo_pkg::MORPH_W-1:0] morph_reg;
    logic [mwo_pkg::NSET_W-1:0]  num_sets_reg;
    logic [mwo_pkg::MAX_SETS-1:0][mwo_pkg::CNT_W-1:0] counts_reg;

    logic                         m_valid_reg;
    logic [mwo_pkg::SAMPLE_W-1:0] m_data_reg;
    logic                         m_found_reg;

    logic                         accept;
    mwo_pkg::cmd_t                cmd;
    logic [mwo_pkg::SET_W-1:0]    in_set;
    logic [mwo_pkg::TAB_W-1:0]    in_tab;
    logic [mwo_pkg::SMP_W-1:0]    in_smp;
    logic [mwo_pkg::SAMPLE_W-1:0] in_val;
    logic [mwo_pkg::PHASE_W-1:0]  in_lim;
    logic [mwo_pkg::CNT_W-1:0]    in_cnt;
    logic [mwo_pkg::CNT_W-1:0]    cnt_sat;

    logic                         idle;
    logic                         out_free;
    mwo_pkg::rd_req_t             rd;
    mwo_pkg::res_t                res;
    logic signed [mwo_pkg::DIFF_W-1:0] mul_a;
    logic [mwo_pkg::PHASE_W-1:0]  mul_b;
    logic signed [mwo_pkg::PROD_W-1:0] prod;
    logic [mwo_pkg::PHASE_W-1:0]  lim_rdata;
    logic [mwo_pkg::SAMPLE_W-1:0] smp_rdata;

    // Unpack the input word
    assign cmd    = mwo_pkg::cmd_t'(s_tuser);
    assign in_set = s_tdata[1:0];
    assign in_tab = s_tdata[4:2];
    assign in_smp = s_tdata[15:5];
    assign in_val = s_tdata[31:16];
    assign in_lim = s_tdata[63:32];
    assign in_cnt = s_tdata[67:64];
    assign cnt_sat = (in_cnt > mwo_pkg::CNT_W'(mwo_pkg::TABLES_PER_SET)) ?
                     mwo_pkg::CNT_W'(mwo_pkg::TABLES_PER_SET) : in_cnt;

    assign s_tready = idle;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Configuration registers and set table counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            morph_reg      <= '0;
            num_sets_reg   <= '0;
            counts_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mwo_pkg::CFG_PHASE_STEP: phase_step_reg <= cfg_data;
                    mwo_pkg::CFG_MORPH:      morph_reg <= cfg_data[mwo_pkg::MORPH_W-1:0];
                    mwo_pkg::CFG_NUM_SETS:   num_sets_reg <= cfg_data[mwo_pkg::NSET_W-1:0];
                    default:                 ;
                endcase
            end
            if (accept && cmd == mwo_pkg::CMD_COUNT)
            begin
                counts_reg[in_set] <= cnt_sat;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res.valid && out_free)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && out_free)
        begin
            m_data_reg  <= res.sample;
            m_found_reg <= res.found;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_found_reg;

    // Sample store
    mwo_ram #(
        .WIDTH (mwo_pkg::SAMPLE_W),
        .DEPTH (mwo_pkg::STORE_DEPTH)
    ) u_samples (
        .clk   (clk),
        .we    (accept && cmd == mwo_pkg::CMD_SAMPLE),
        .waddr ({in_set, in_tab, in_smp}),
        .wdata (in_val),
        .raddr (rd.smp_raddr),
        .rdata (smp_rdata)
    );

    // Table limit store
    mwo_ram #(
        .WIDTH (mwo_pkg::PHASE_W),
        .DEPTH (mwo_pkg::LIM_DEPTH)
    ) u_limits (
        .clk   (clk),
        .we    (accept && cmd == mwo_pkg::CMD_LIMIT),
        .waddr ({in_set, in_tab}),
        .wdata (in_lim),
        .raddr (rd.lim_raddr),
        .rdata (lim_rdata)
    );

    mwo_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    mwo_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept && cmd == mwo_pkg::CMD_PRODUCE),
        .phase_step   (phase_step_reg),
        .morph_amount (morph_reg),
        .num_sets     (num_sets_reg),
        .set_counts   (counts_reg),
        .lim_rdata    (lim_rdata),
        .smp_rdata    (smp_rdata),
        .prod         (prod),
        .out_free     (out_free),
        .rd           (rd),
        .mul_a        (mul_a),
        .mul_b        (mul_b),
        .idle         (idle),
        .res          (res)
    );

    // A produce word closes the input until its result is handed over
    a_produce_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == mwo_pkg::CMD_PRODUCE) |=> !s_tready)
        else $error("input still open after a produce word");

    // Load words never stall the input
    a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd != mwo_pkg::CMD_PRODUCE) |=> s_tready)
        else $error("input closed after a load word");

    // A new output word only follows a finished sequence
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("output word appeared without a finished sequence");

endmodule
